[design/assert_macros.svh]
// Assertion helpers shared by the RTL; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[design/ddo_pkg.sv]
package ddo_pkg;

  localparam int STEP_W    = 16;
  localparam int CFG_W     = 24;
  localparam int TIME_W    = 24;
  localparam int POS_W     = 32;
  localparam int ANG_W     = 16;
  localparam int VEL_W     = 32;
  localparam int FINE_W    = 41;
  localparam int MCAND_W   = 48;
  localparam int PROD_W    = 64;
  localparam int MPLIER_W  = 24;
  localparam int NBITS_W   = 5;
  localparam int NUM_W     = 44;
  localparam int DIV_CNT_W = 6;
  localparam int DX_W      = 26;
  localparam int CORD_W    = 33;
  localparam int Z_W       = 32;
  localparam int ITER_W    = 4;

  localparam logic [CFG_W-1:0]    HPS_RESET = 24'd1683658;
  localparam logic [CFG_W-1:0]    DPS_RESET = 24'd4447318;
  localparam logic [CORD_W-1:0]   CORDIC_X0 = 33'd652032874;
  localparam logic [MPLIER_W-1:0] VEL_SCALE = 24'd1000000;

  localparam logic [NBITS_W-1:0] NB_CFG   = 5'd24;
  localparam logic [NBITS_W-1:0] NB_TRIG  = 5'd16;
  localparam logic [NBITS_W-1:0] NB_SCALE = 5'd20;

  typedef enum logic [1:0] {
    OP_UPDATE   = 2'd0,
    OP_SET_POSE = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  typedef enum logic {
    REG_HEADING_PER_STEP  = 1'b0,
    REG_DISTANCE_PER_STEP = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                start;
    logic                b_signed;
    logic [NBITS_W-1:0]  nbits;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
    logic [Z_W-1:0] a;
    unique case (i)
      4'd0:  a = 32'h20000000;
      4'd1:  a = 32'h12E4051E;
      4'd2:  a = 32'h09FB385B;
      4'd3:  a = 32'h051111D4;
      4'd4:  a = 32'h028B0D43;
      4'd5:  a = 32'h0145D7E1;
      4'd6:  a = 32'h00A2F61E;
      4'd7:  a = 32'h00517C55;
      4'd8:  a = 32'h0028BE53;
      4'd9:  a = 32'h00145F2F;
      4'd10: a = 32'h000A2F98;
      4'd11: a = 32'h000517CC;
      4'd12: a = 32'h00028BE6;
      4'd13: a = 32'h000145F3;
      4'd14: a = 32'h0000A2FA;
      4'd15: a = 32'h0000517D;
    endcase
    return a;
  endfunction

endpackage

[design/ddo_mul.sv]
module ddo_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ddo_pkg::mul_req_t                     req,
  input  logic signed [ddo_pkg::MCAND_W-1:0]    a,
  input  logic [ddo_pkg::MPLIER_W-1:0]          b,
  output ddo_pkg::unit_stat_t                   stat,
  output logic signed [ddo_pkg::PROD_W-1:0]     product
);
  import ddo_pkg::*;

  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] mcand;
  logic signed [PROD_W-1:0] addend;
  logic [MPLIER_W-1:0]      mplier;
  logic [NBITS_W-1:0]       cnt;
  logic                     neg_top;
  logic                     busy;
  logic                     done;
  logic                     last;

  assign last   = (cnt == NBITS_W'(1));
  assign addend = mplier[0] ? mcand : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - NBITS_W'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per cycle; the top bit of a signed multiplier weighs negative
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc     <= '0;
      mcand   <= {{(PROD_W-MCAND_W){a[MCAND_W-1]}}, a};
      mplier  <= b;
      neg_top <= req.b_signed;
    end else if (busy) begin
      acc    <= (last && neg_top) ? acc - addend : acc + addend;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign stat    = '{busy: busy, done: done};
  assign product = acc;

endmodule

[design/ddo_div.sv]
module ddo_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ddo_pkg::NUM_W-1:0]      num,
  input  logic [ddo_pkg::TIME_W-1:0]     den,
  output ddo_pkg::unit_stat_t            stat,
  output logic [ddo_pkg::NUM_W-1:0]      quotient
);
  import ddo_pkg::*;

  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    dvs;
  logic [NUM_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W+1:0]    trial;
  logic                 fits;
  logic                 busy;
  logic                 done;

  assign trial = {1'b0, rem, quo[NUM_W-1]} - {2'b00, dvs};
  assign fits  = ~trial[TIME_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? trial[TIME_W-1:0] : {rem[TIME_W-2:0], quo[NUM_W-1]};
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign quotient = quo;

endmodule

[design/differential_drive_odometry.sv]
// Set pose, clear and the unused code go straight to the result. An update with zero elapsed
// time runs two 24-bit and two 16-bit serial multiplies around 16 CORDIC rotations, and
// other updates add three 20-bit multiplies, each followed by a 44-bit restoring division.
// One item in flight: the next transaction is taken the cycle after the result loads.
// Synchronous reset clears pose, velocity and handshake state and reloads registers.
`include "assert_macros.svh"
module differential_drive_odometry (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          operation,
  input  logic signed [ddo_pkg::STEP_W-1:0]   right_count,
  input  logic signed [ddo_pkg::STEP_W-1:0]   left_count,
  input  logic [ddo_pkg::TIME_W-1:0]          elapsed_us,
  input  logic signed [ddo_pkg::POS_W-1:0]    new_x,
  input  logic signed [ddo_pkg::POS_W-1:0]    new_y,
  input  logic signed [ddo_pkg::ANG_W-1:0]    new_theta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ddo_pkg::POS_W-1:0]    pose_x,
  output logic signed [ddo_pkg::POS_W-1:0]    pose_y,
  output logic signed [ddo_pkg::ANG_W-1:0]    pose_theta,
  output logic signed [ddo_pkg::VEL_W-1:0]    vel_x,
  output logic signed [ddo_pkg::VEL_W-1:0]    vel_y,
  output logic signed [ddo_pkg::VEL_W-1:0]    vel_theta,
  output logic                                time_invalid,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]           cfg_data
);
  import ddo_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MUL_T  = 10'b0000000010,
    S_MUL_L  = 10'b0000000100,
    S_CORDIC = 10'b0000001000,
    S_SCALE  = 10'b0000010000,
    S_MUL_C  = 10'b0000100000,
    S_MUL_S  = 10'b0001000000,
    S_MUL_V  = 10'b0010000000,
    S_DIV_V  = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  localparam logic signed [Z_W-1:0] QUARTER_POS = 32'sh4000_0000;
  localparam logic signed [Z_W-1:0] QUARTER_NEG = 32'shC000_0000;

  state_t state, state_next;

  logic [CFG_W-1:0] hps;
  logic [CFG_W-1:0] dps;

  logic signed [POS_W-1:0] xpos, ypos;
  logic [ANG_W-1:0]        head;
  logic signed [VEL_W-1:0] vx, vy, vth;
  logic                    invalid;

  logic signed [STEP_W:0]  sum, diff_in, sum_in;
  logic [TIME_W-1:0]       dt;
  logic signed [FINE_W-1:0] tfine, lfine;
  logic signed [CORD_W-1:0] cx, cy, cx_n, cy_n, xsh, ysh;
  logic signed [Z_W-1:0]   cz, cz_n, zinit, at;
  logic [ITER_W-1:0]       citer;
  logic                    cneg, zflip;
  logic signed [ANG_W-1:0] cos_c, sin_c, sin_q;
  logic signed [DX_W-1:0]  dx, dy, rnd_c;
  logic [1:0]              vel_sel;
  logic                    vneg;
  logic [ANG_W-1:0]        dth;
  logic [FINE_W:0]         t_r;
  logic [PROD_W-1:0]       rnd_full, mag;
  logic [NUM_W-1:0]        vel_num;
  logic [VEL_W-1:0]        vel_sat;
  logic                    out_free;

  mul_req_t                 mul_req;
  logic signed [MCAND_W-1:0] mul_a;
  logic [MPLIER_W-1:0]      mul_b;
  unit_stat_t               mul_stat;
  logic signed [PROD_W-1:0] mul_p;
  logic                     div_start;
  unit_stat_t               div_stat;
  logic [NUM_W-1:0]         div_q;

  function automatic logic signed [ANG_W-1:0] to_q15(input logic signed [CORD_W-1:0] v,
                                                     input logic flip);
    logic signed [CORD_W:0]    full;
    logic signed [CORD_W-15:0] r;
    logic signed [ANG_W-1:0]   c;
    full = {v[CORD_W-1], v} + (CORD_W+1)'(16384);
    r    = full[CORD_W:15];
    if (r > 19'sd32767) c = 16'sd32767;
    else if (r < -19'sd32767) c = -16'sd32767;
    else c = r[ANG_W-1:0];
    return flip ? -c : c;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] p,
                                                      input logic signed [DX_W-1:0] d);
    logic signed [POS_W:0] s;
    s = {p[POS_W-1], p} + {{(POS_W+1-DX_W){d[DX_W-1]}}, d};
    if (s[POS_W] != s[POS_W-1]) return s[POS_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[POS_W-1:0];
  endfunction

  ddo_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .a       (mul_a),
    .b       (mul_b),
    .stat    (mul_stat),
    .product (mul_p)
  );

  ddo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (vel_num),
    .den      (dt),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = ~out_valid | ~out_stall;

  assign diff_in = {right_count[STEP_W-1], right_count}
                 - {left_count[STEP_W-1], left_count};
  assign sum_in  = {right_count[STEP_W-1], right_count}
                 + {left_count[STEP_W-1], left_count};

  // heading step, rounded to the nearest binary-angle LSB
  assign t_r = {tfine[FINE_W-1], tfine} + (FINE_W+1)'(32768);
  assign dth = t_r[31:16];

  // CORDIC rotation
  assign xsh = cx >>> citer;
  assign ysh = cy >>> citer;
  assign at  = atan_entry(citer);
  always_comb begin
    if (!cz[Z_W-1]) begin
      cx_n = cx - ysh;
      cy_n = cy + xsh;
      cz_n = cz - at;
    end else begin
      cx_n = cx + ysh;
      cy_n = cy - xsh;
      cz_n = cz + at;
    end
  end

  // fold angles beyond a quarter turn by half a turn
  always_comb begin
    zinit = {head, 16'h0000};
    zflip = (zinit > QUARTER_POS) || (zinit < QUARTER_NEG);
    if (zflip) zinit = {~zinit[Z_W-1], zinit[Z_W-2:0]};
  end

  assign cos_c = to_q15(cx, cneg);
  assign sin_c = to_q15(cy, cneg);

  assign rnd_full = mul_p + PROD_W'(64'h4000_0000);
  assign rnd_c    = rnd_full[31+DX_W-1:31];

  always_comb begin
    mag = mul_p[PROD_W-1] ? -mul_p : mul_p;
    if (vel_sel == 2'd2) mag = mag >> 16;
    vel_num = mag[NUM_W-1:0];
  end

  always_comb begin
    if (vneg) begin
      if ((div_q[NUM_W-1:VEL_W] != '0) || (div_q[VEL_W-1] && (div_q[VEL_W-2:0] != '0)))
        vel_sat = 32'h8000_0000;
      else
        vel_sat = -div_q[VEL_W-1:0];
    end else begin
      if (div_q[NUM_W-1:VEL_W-1] != '0) vel_sat = 32'h7FFF_FFFF;
      else vel_sat = div_q[VEL_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    mul_req    = '0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(operation) == OP_UPDATE) begin
            state_next    = S_MUL_T;
            mul_req.start = 1'b1;
            mul_req.nbits = NB_CFG;
            mul_a         = {{(MCAND_W-STEP_W-1){diff_in[STEP_W]}}, diff_in};
            mul_b         = hps;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_MUL_T: begin
        if (mul_stat.done) begin
          state_next    = S_MUL_L;
          mul_req.start = 1'b1;
          mul_req.nbits = NB_CFG;
          mul_a         = {{(MCAND_W-STEP_W-1){sum[STEP_W]}}, sum};
          mul_b         = dps;
        end
      end
      S_MUL_L: if (mul_stat.done) state_next = S_CORDIC;
      S_CORDIC: if (citer == '1) state_next = S_SCALE;
      S_SCALE: begin
        state_next       = S_MUL_C;
        mul_req.start    = 1'b1;
        mul_req.b_signed = 1'b1;
        mul_req.nbits    = NB_TRIG;
        mul_a            = {{(MCAND_W-FINE_W){lfine[FINE_W-1]}}, lfine};
        mul_b            = {{(MPLIER_W-ANG_W){1'b0}}, cos_c};
      end
      S_MUL_C: begin
        if (mul_stat.done) begin
          state_next       = S_MUL_S;
          mul_req.start    = 1'b1;
          mul_req.b_signed = 1'b1;
          mul_req.nbits    = NB_TRIG;
          mul_a            = {{(MCAND_W-FINE_W){lfine[FINE_W-1]}}, lfine};
          mul_b            = {{(MPLIER_W-ANG_W){1'b0}}, sin_q};
        end
      end
      S_MUL_S: begin
        if (mul_stat.done) begin
          if (dt == '0) begin
            state_next = S_FINISH;
          end else begin
            state_next    = S_MUL_V;
            mul_req.start = 1'b1;
            mul_req.nbits = NB_SCALE;
            mul_a         = {{(MCAND_W-DX_W){dx[DX_W-1]}}, dx};
            mul_b         = VEL_SCALE;
          end
        end
      end
      S_MUL_V: begin
        if (mul_stat.done) begin
          state_next = S_DIV_V;
          div_start  = 1'b1;
        end
      end
      S_DIV_V: begin
        if (div_stat.done) begin
          if (vel_sel == 2'd2) begin
            state_next = S_FINISH;
          end else begin
            state_next    = S_MUL_V;
            mul_req.start = 1'b1;
            mul_req.nbits = NB_SCALE;
            mul_b         = VEL_SCALE;
            if (vel_sel == 2'd0) mul_a = {{(MCAND_W-DX_W){dy[DX_W-1]}}, dy};
            else mul_a = {{(MCAND_W-FINE_W){tfine[FINE_W-1]}}, tfine};
          end
        end
      end
      S_FINISH: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hps       <= HPS_RESET;
      dps       <= DPS_RESET;
      xpos      <= '0;
      ypos      <= '0;
      head      <= '0;
      vx        <= '0;
      vy        <= '0;
      vth       <= '0;
      invalid   <= 1'b0;
      citer     <= '0;
      vel_sel   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (reg_idx_t'(cfg_index))
          REG_HEADING_PER_STEP:  hps <= cfg_data;
          REG_DISTANCE_PER_STEP: dps <= cfg_data;
        endcase
      end
      if ((state == S_FINISH) && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            invalid <= 1'b0;
            unique case (op_t'(operation))
              OP_SET_POSE: begin
                xpos <= new_x;
                ypos <= new_y;
                head <= new_theta;
              end
              OP_CLEAR: begin
                xpos <= '0;
                ypos <= '0;
                head <= '0;
                vx   <= '0;
                vy   <= '0;
                vth  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CORDIC: citer <= citer + ITER_W'(1);
        S_MUL_S: begin
          if (mul_stat.done) begin
            xpos    <= sat_add(xpos, dx);
            ypos    <= sat_add(ypos, rnd_c);
            head    <= head + dth;
            vel_sel <= '0;
            if (dt == '0) begin
              vx      <= '0;
              vy      <= '0;
              vth     <= '0;
              invalid <= 1'b1;
            end
          end
        end
        S_DIV_V: begin
          if (div_stat.done) begin
            vel_sel <= vel_sel + 2'd1;
            unique case (vel_sel)
              2'd0:    vx  <= vel_sat;
              2'd1:    vy  <= vel_sat;
              default: vth <= vel_sat;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          sum  <= sum_in;
          dt   <= elapsed_us;
        end
      end
      S_MUL_T: if (mul_stat.done) tfine <= mul_p[FINE_W-1:0];
      S_MUL_L: begin
        if (mul_stat.done) begin
          lfine <= mul_p[FINE_W-1:0];
          cx    <= CORDIC_X0;
          cy    <= '0;
          cz    <= zinit;
          cneg  <= zflip;
        end
      end
      S_CORDIC: begin
        cx <= cx_n;
        cy <= cy_n;
        cz <= cz_n;
      end
      S_SCALE: sin_q <= sin_c;
      S_MUL_C: if (mul_stat.done) dx <= rnd_c;
      S_MUL_S: if (mul_stat.done) dy <= rnd_c;
      S_MUL_V: if (mul_stat.done) vneg <= mul_p[PROD_W-1];
      S_FINISH: begin
        if (out_free) begin
          pose_x       <= xpos;
          pose_y       <= ypos;
          pose_theta   <= head;
          vel_x        <= vx;
          vel_y        <= vy;
          vel_theta    <= vth;
          time_invalid <= invalid;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMP(a_mul_free, clk, rst, mul_req.start, !mul_stat.busy)
  `ASSERT_IMP(a_div_free, clk, rst, div_start, !div_stat.busy)
  `ASSERT_NXT(a_out_load, clk, rst, (state == S_FINISH) && out_free, out_valid)
  `ASSERT_IMP(a_inv_zero, clk, rst, out_valid && time_invalid, (vel_x | vel_y | vel_theta) == '0)

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddo_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [ANG_W-1:0] theta;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vtheta;
    logic                    invalid;
  } pose_t;

  typedef struct {
    logic [1:0]               op;
    logic signed [STEP_W-1:0] right;
    logic signed [STEP_W-1:0] left;
    logic [TIME_W-1:0]        dt;
    logic signed [POS_W-1:0]  nx;
    logic signed [POS_W-1:0]  ny;
    logic signed [ANG_W-1:0]  nth;
    bit                       typed;
    pose_t                    fixed;
  } odo_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = OP_CLEAR;
  logic signed [STEP_W-1:0] right_count = '0;
  logic signed [STEP_W-1:0] left_count = '0;
  logic [TIME_W-1:0] elapsed_us = '0;
  logic signed [POS_W-1:0] new_x = '0;
  logic signed [POS_W-1:0] new_y = '0;
  logic signed [ANG_W-1:0] new_theta = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] pose_x, pose_y;
  logic signed [ANG_W-1:0] pose_theta;
  logic signed [VEL_W-1:0] vel_x, vel_y, vel_theta;
  logic time_invalid;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_HEADING_PER_STEP;
  logic [CFG_W-1:0] cfg_data = '0;

  differential_drive_odometry dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // odometry state mirrored for prediction
  longint hps, dps;
  longint odo_x, odo_y, odo_vx, odo_vy, odo_vt;
  logic [ANG_W-1:0] odo_heading;
  pose_t pending_poses[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  longint arctan[16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  function automatic void heading_trig(input logic [ANG_W-1:0] ang,
                                       output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'($signed(ang)) * 65536;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan[i];
      end
      x = nx;
    end
    c = to_q15(x);
    s = to_q15(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic pose_t integrate(odo_item_t it);
    longint sr, sl, dt, tfine, dth, lfine, c, s, dx, dy;
    pose_t p;
    p.invalid = 1'b0;
    if (it.op == OP_UPDATE) begin
      sr = it.right;
      sl = it.left;
      dt = it.dt;
      tfine = (sr - sl) * hps;
      dth = (tfine + 32768) >>> 16;
      lfine = (sr + sl) * dps;
      heading_trig(odo_heading, c, s);
      dx = (lfine * c + 64'sd1073741824) >>> 31;
      dy = (lfine * s + 64'sd1073741824) >>> 31;
      if (dt == 0) begin
        odo_vx = 0;
        odo_vy = 0;
        odo_vt = 0;
        p.invalid = 1'b1;
      end else begin
        odo_vx = sat32(dx * 1000000 / dt);
        odo_vy = sat32(dy * 1000000 / dt);
        odo_vt = sat32(tfine * 1000000 / (dt * 65536));
      end
      odo_x = sat32(odo_x + dx);
      odo_y = sat32(odo_y + dy);
      odo_heading = odo_heading + dth[ANG_W-1:0];
    end else if (it.op == OP_SET_POSE) begin
      odo_x = it.nx;
      odo_y = it.ny;
      odo_heading = it.nth;
    end else if (it.op == OP_CLEAR) begin
      odo_x = 0;
      odo_y = 0;
      odo_heading = '0;
      odo_vx = 0;
      odo_vy = 0;
      odo_vt = 0;
    end
    p.x = odo_x[31:0];
    p.y = odo_y[31:0];
    p.theta = odo_heading;
    p.vx = odo_vx[31:0];
    p.vy = odo_vy[31:0];
    p.vtheta = odo_vt[31:0];
    return p;
  endfunction

  function automatic odo_item_t mk(logic [1:0] op, int r, int l, int dt,
                                   int nx, int ny, int nth);
    odo_item_t it;
    it.op = op;
    it.right = STEP_W'(r);
    it.left = STEP_W'(l);
    it.dt = TIME_W'(dt);
    it.nx = nx;
    it.ny = ny;
    it.nth = ANG_W'(nth);
    it.typed = 0;
    it.fixed = '{0, 0, '0, 0, 0, 0, 1'b0};
    return it;
  endfunction

  function automatic odo_item_t fixed(odo_item_t it, int x, int y, int th, bit inv);
    it.typed = 1;
    it.fixed = '{x, y, ANG_W'(th), 0, 0, 0, inv};
    return it;
  endfunction

  function automatic odo_item_t random_item();
    odo_item_t it;
    int sel;
    it = mk(OP_UPDATE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    sel = $urandom_range(0, 99);
    if (sel < 8) it.op = OP_SET_POSE;
    else if (sel < 11) it.op = OP_CLEAR;
    else if (sel < 14) it.op = OP_UNUSED;
    if (it.op == OP_SET_POSE && $urandom_range(0, 1)) begin
      it.nx = $signed($urandom_range(0, 2000000)) - 1000000;
      it.ny = $signed($urandom_range(0, 2000000)) - 1000000;
    end
    if ($urandom_range(0, 4) != 0) begin
      it.right = STEP_W'($signed($urandom_range(0, 600)) - 300);
      it.left = STEP_W'($signed($urandom_range(0, 600)) - 300);
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) it.dt = '0;
    else if (sel < 5) it.dt = TIME_W'($urandom_range(1, 2000));
    else if (sel < 7) it.dt = TIME_W'($urandom_range(1, 65535));
    return it;
  endfunction

  // send one transaction; valid stays high through back-to-back items
  task automatic send(odo_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= it.op;
    right_count <= it.right;
    left_count <= it.left;
    elapsed_us <= it.dt;
    new_x <= it.nx;
    new_y <= it.ny;
    new_theta <= it.nth;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (it.typed) begin
      void'(integrate(it));
      pending_poses.push_back(it.fixed);
    end else begin
      pending_poses.push_back(integrate(it));
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_HEADING_PER_STEP) hps = value;
    else dps = value;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual x %0d", $realtime, pose_x);
      end else begin
        pose_t want;
        want = pending_poses.pop_front();
        check_field("pose_x", want.x, pose_x);
        check_field("pose_y", want.y, pose_y);
        check_field("pose_theta", want.theta, pose_theta);
        check_field("vel_x", want.vx, vel_x);
        check_field("vel_y", want.vy, vel_y);
        check_field("vel_theta", want.vtheta, vel_theta);
        check_field("time_invalid", want.invalid, time_invalid);
      end
    end
  end

  // receiver stall pattern: switches among four randomly chosen modes
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycles % 7 < 3);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    odo_item_t rows[$];
    hps = HPS_RESET;
    dps = DPS_RESET;
    odo_x = 0;
    odo_y = 0;
    odo_heading = '0;
    odo_vx = 0;
    odo_vy = 0;
    odo_vt = 0;

    rows.push_back(fixed(mk(OP_CLEAR, 5, 7, 9, 1, 2, 3), 0, 0, 0, 0));
    rows.push_back(fixed(mk(OP_UPDATE, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1));
    rows.push_back(fixed(mk(OP_SET_POSE, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32767),
                         32'h7FFFFFFF, 32'h80000000, 32767, 0));
    rows.push_back(fixed(mk(OP_UNUSED, -1, -1, 24'hFFFFFF, 0, 0, 0),
                         32'h7FFFFFFF, 32'h80000000, 32767, 0));
    rows.push_back(mk(OP_UPDATE, 32767, 32767, 1, 0, 0, 0));
    rows.push_back(mk(OP_UPDATE, -32768, -32768, 24'hFFFFFF, 0, 0, 0));
    rows.push_back(mk(OP_UPDATE, 32767, -32768, 1, 0, 0, 0));
    rows.push_back(mk(OP_UPDATE, -32768, 32767, 0, 0, 0, 0));
    rows.push_back(mk(OP_SET_POSE, 0, 0, 0, 0, 0, -32768));
    rows.push_back(mk(OP_UPDATE, 100, 100, 1000, 0, 0, 0));
    rows.push_back(mk(OP_SET_POSE, 0, 0, 0, 0, 0, 16384));
    rows.push_back(mk(OP_UPDATE, 1000, 1000, 5000, 0, 0, 0));
    rows.push_back(mk(OP_SET_POSE, 0, 0, 0, 0, 0, -16384));
    rows.push_back(mk(OP_UPDATE, 1000, 1000, 5000, 0, 0, 0));
    rows.push_back(mk(OP_SET_POSE, 0, 0, 0, 0, 0, 16385));
    rows.push_back(mk(OP_UPDATE, -1000, -1000, 3, 0, 0, 0));
    rows.push_back(fixed(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    rows.push_back(mk(OP_UPDATE, 1, 0, 1, 0, 0, 0));
    rows.push_back(mk(OP_UPDATE, 0, 1, 1, 0, 0, 0));
    rows.push_back(mk(OP_SET_POSE, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0));
    rows.push_back(mk(OP_UPDATE, -32768, -32768, 1, 0, 0, 0));
    rows.push_back(mk(OP_SET_POSE, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 8192));
    rows.push_back(mk(OP_UPDATE, 32767, 32767, 100, 0, 0, 0));
    rows.push_back(mk(OP_UNUSED, 3, 3, 3, 3, 3, 3));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i]);
    repeat (380) send(random_item());

    // walk the scale registers through zero, full scale, random values and one
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_HEADING_PER_STEP, '0);
          write_reg(REG_DISTANCE_PER_STEP, '0);
        end
        1: begin
          write_reg(REG_HEADING_PER_STEP, 24'hFFFFFF);
          write_reg(REG_DISTANCE_PER_STEP, 24'hFFFFFF);
        end
        2: begin
          write_reg(REG_HEADING_PER_STEP, CFG_W'($urandom));
          write_reg(REG_DISTANCE_PER_STEP, CFG_W'($urandom));
        end
        default: begin
          write_reg(REG_HEADING_PER_STEP, 24'd1);
          write_reg(REG_DISTANCE_PER_STEP, 24'd1);
        end
      endcase
      repeat (325) send(random_item());
    end
    in_valid <= 1'b0;

    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
